@@ hdl/sed_pkg.sv @@
package sed_pkg;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] high_nibble;
    logic       at_first;
    logic       err;
  } dec_state_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       bad_escape;
  } dec_result_t;

  localparam dec_state_t STATE_RESET = '{
    phase: PH_TEXT, high_nibble: 4'd0, at_first: 1'b1, err: 1'b0
  };

  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LOW_A     = 8'h61;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_V     = 8'h76;
  localparam logic [7:0] CH_LOW_X     = 8'h78;
  localparam logic [7:0] TEN          = 8'h0A;

  // bit 4 set marks a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] low;
    logic [7:0] diff;
    low = c | CASE_BIT;
    hex_value = 5'h10;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff = c - CH_ZERO;
      hex_value = {1'b0, diff[3:0]};
    end else if (low >= CH_LOW_A && low <= CH_LOW_F) begin
      diff = low - CH_LOW_A + TEN;
      hex_value = {1'b0, diff[3:0]};
    end
  endfunction

endpackage

@@ hdl/string_escape_decoder_top.sv @@
// a byte passes the input register, then the result register, to the
// master side; one byte per cycle unless the master side stalls; the
// decoder state loops through the decode logic between both registers
// synchronous active-high reset empties both registers, sets strip_quotes
// to 1 and returns the decoder to the start of a literal
module string_escape_decoder_top
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,        // strip_quotes
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic [1:0] m_axis_tuser,    // [0] has_byte, [1] bad_escape
  output logic       m_axis_tlast
);

  logic        strip_quotes;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  dec_state_t  st;
  dec_state_t  st_next;
  dec_result_t res;
  dec_result_t out_reg;

  assign cfg_ready     = 1'b1;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  sed_decode u_decode (
    .st           (st),
    .strip_quotes (strip_quotes),
    .data_byte    (in_byte),
    .last_byte    (in_last),
    .st_next      (st_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_quotes  <= 1'b1;
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      st            <= STATE_RESET;
    end else begin
      if (cfg_valid) begin
        strip_quotes <= cfg_data;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= in_valid;
        if (in_valid) begin
          st <= st_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance && in_valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = out_reg.out_byte;
  assign m_axis_tuser = {out_reg.bad_escape, out_reg.has_byte};
  assign m_axis_tlast = out_reg.end_of_string;

endmodule

@@ hdl/sed_decode.sv @@
module sed_decode
  import sed_pkg::*;
(
  input  dec_state_t  st,
  input  logic        strip_quotes,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output dec_state_t  st_next,
  output dec_result_t res
);

  dec_state_t nxt;
  logic       has;
  logic [7:0] ob;
  logic [4:0] hv;
  logic       dropped;
  logic       err_fin;

  assign hv      = hex_value(data_byte);
  assign dropped = strip_quotes && (st.at_first || last_byte);

  always_comb begin
    nxt = st;
    has = 1'b0;
    ob  = 8'h00;
    if (!dropped && !st.err) begin
      unique case (st.phase)
        PH_TEXT: begin
          if (data_byte == CH_BACKSLASH) begin
            nxt.phase = PH_ESC;
          end else begin
            has = 1'b1;
            ob  = data_byte;
          end
        end
        PH_ESC: begin
          nxt.phase = PH_TEXT;
          has       = 1'b1;
          unique case (data_byte)
            CH_LOW_A:     ob = 8'h07;
            CH_LOW_B:     ob = 8'h08;
            CH_LOW_F:     ob = 8'h0C;
            CH_LOW_N:     ob = 8'h0A;
            CH_LOW_R:     ob = 8'h0D;
            CH_LOW_T:     ob = 8'h09;
            CH_LOW_V:     ob = 8'h0B;
            CH_ZERO:      ob = 8'h00;
            CH_BACKSLASH: ob = CH_BACKSLASH;
            CH_QUOTE:     ob = CH_QUOTE;
            CH_DQUOTE:    ob = CH_DQUOTE;
            CH_LOW_X: begin
              has       = 1'b0;
              nxt.phase = PH_HEX1;
            end
            default: begin
              has     = 1'b0;
              nxt.err = 1'b1;
            end
          endcase
        end
        PH_HEX1: begin
          if (hv[4]) begin
            nxt.phase = PH_TEXT;
            nxt.err   = 1'b1;
          end else begin
            nxt.high_nibble = hv[3:0];
            nxt.phase       = PH_HEX2;
          end
        end
        PH_HEX2: begin
          nxt.phase = PH_TEXT;
          if (hv[4]) begin
            nxt.err = 1'b1;
          end else begin
            has = 1'b1;
            ob  = {st.high_nibble, hv[3:0]};
          end
        end
        default: nxt.phase = PH_TEXT;
      endcase
    end

    // a literal that closes inside an escape is an error
    err_fin = nxt.err || (last_byte && nxt.phase != PH_TEXT);

    if (last_byte) begin
      st_next = STATE_RESET;
    end else begin
      st_next          = nxt;
      st_next.at_first = 1'b0;
    end
  end

  assign res = '{
    has_byte: has, out_byte: ob, end_of_string: last_byte, bad_escape: err_fin
  };

endmodule

@@ hdl/sed_checker.sv @@
module sed_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // no decoded byte means a zero data byte
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("data not zero without has_byte");

  // input only backs up when the result side stalls
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with free result register");

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ test/tb_string_escape_decoder_top.sv @@
module tb_string_escape_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;      // register value in bit 0 for ROW_CFG
    logic        last;
    logic        typed;     // res holds a hand-written expectation
    dec_result_t res;
  } plan_row_t;

  localparam int N_ROWS = 26;

  localparam plan_row_t PLAN [N_ROWS] = '{
    // quoted mode after reset: lone byte is both quotes
    '{ROW_BYTE, 8'h41, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0}},
    '{ROW_BYTE, 8'h22, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'h5C, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    // stripped closing quote still ends inside the escape
    '{ROW_BYTE, 8'h22, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b0}},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'h5C, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'h6E, 1'b0, 1'b1, '{1'b1, 8'h0A, 1'b0, 1'b0}},
    // hex escape, mixed case digits
    '{ROW_BYTE, 8'h5C, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h78, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h41, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h66, 1'b0, 1'b0, '0},
    // bad first hex digit, then a byte after the error
    '{ROW_BYTE, 8'h5C, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h78, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h67, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{ROW_BYTE, 8'h7A, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
    // unknown escape
    '{ROW_BYTE, 8'h5C, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h71, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{ROW_BYTE, 8'h61, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
    // bad second hex digit on the last byte
    '{ROW_BYTE, 8'h5C, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h78, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h33, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h5A, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
    // literal ends right after a backslash
    '{ROW_BYTE, 8'h5C, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
    '{ROW_CFG,  8'h01, 1'b0, 1'b0, '0}
  };

  localparam logic [7:0] ESC_CHARS [11] = '{
    CH_LOW_A, CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_V,
    CH_ZERO, CH_BACKSLASH, CH_QUOTE, CH_DQUOTE
  };

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  // decoder shadow
  logic       strip_en;
  phase_t     esc_phase;
  logic [3:0] hi_nib;
  logic       at_start;
  logic       err_flag;

  dec_result_t decoded_q [$];
  logic [7:0]  lit_q [$];
  int          mismatches;
  logic        calm;

  string_escape_decoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // bit 8 set when c is a single-character escape
  function automatic logic [8:0] escape_map(input logic [7:0] c);
    case (c)
      CH_LOW_A:     return {1'b1, 8'h07};
      CH_LOW_B:     return {1'b1, 8'h08};
      CH_LOW_F:     return {1'b1, 8'h0C};
      CH_LOW_N:     return {1'b1, 8'h0A};
      CH_LOW_R:     return {1'b1, 8'h0D};
      CH_LOW_T:     return {1'b1, 8'h09};
      CH_LOW_V:     return {1'b1, 8'h0B};
      CH_ZERO:      return {1'b1, 8'h00};
      CH_BACKSLASH: return {1'b1, CH_BACKSLASH};
      CH_QUOTE:     return {1'b1, CH_QUOTE};
      CH_DQUOTE:    return {1'b1, CH_DQUOTE};
      default:      return 9'h000;
    endcase
  endfunction

  // bit 4 set when c is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, c[3:0]};
    if (lc >= CH_LOW_A && lc <= CH_LOW_F) return {1'b0, lc[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic dec_result_t decode_byte(input logic [7:0] c, input logic last);
    logic       has;
    logic [7:0] ob;
    logic [8:0] em;
    logic [4:0] hv;
    has = 1'b0;
    ob  = 8'h00;
    if (strip_en && (at_start || last)) begin
      // quote bytes are dropped unchecked
    end else if (!err_flag) begin
      case (esc_phase)
        PH_TEXT: begin
          if (c == CH_BACKSLASH) begin
            esc_phase = PH_ESC;
          end else begin
            has = 1'b1;
            ob  = c;
          end
        end
        PH_ESC: begin
          em = escape_map(c);
          esc_phase = PH_TEXT;
          if (em[8]) begin
            has = 1'b1;
            ob  = em[7:0];
          end else if (c == CH_LOW_X) begin
            esc_phase = PH_HEX1;
          end else begin
            err_flag = 1'b1;
          end
        end
        PH_HEX1: begin
          hv = hex_digit(c);
          if (hv[4]) begin
            esc_phase = PH_TEXT;
            err_flag  = 1'b1;
          end else begin
            hi_nib    = hv[3:0];
            esc_phase = PH_HEX2;
          end
        end
        default: begin
          hv = hex_digit(c);
          esc_phase = PH_TEXT;
          if (hv[4]) begin
            err_flag = 1'b1;
          end else begin
            has = 1'b1;
            ob  = {hi_nib, hv[3:0]};
          end
        end
      endcase
    end
    if (last && esc_phase != PH_TEXT) err_flag = 1'b1;
    decode_byte = '{has, ob, last, err_flag};
    if (last) begin
      esc_phase = PH_TEXT;
      hi_nib    = 4'd0;
      err_flag  = 1'b0;
      at_start  = 1'b1;
    end else begin
      at_start  = 1'b0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last,
                           input logic typed, input dec_result_t typed_res);
    int          gap;
    dec_result_t res;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = decode_byte(data, last);
    decoded_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // only while idle; the pause covers the two-stage pipeline
  task automatic write_strip(input logic value);
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    strip_en = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) lit_q.push_back(CH_ZERO + 8'(v));
    else if ($urandom_range(0, 1)) lit_q.push_back(CH_LOW_A + 8'(v - 10));
    else lit_q.push_back(8'h41 + 8'(v - 10));
  endtask

  task automatic push_token();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0, 1: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_BACKSLASH);
        lit_q.push_back(b);
      end
      2: begin
        lit_q.push_back(CH_BACKSLASH);
        lit_q.push_back(ESC_CHARS[$urandom_range(0, 10)]);
      end
      3: begin
        lit_q.push_back(CH_BACKSLASH);
        lit_q.push_back(CH_LOW_X);
        push_hex_char();
        push_hex_char();
      end
      default: lit_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic run_literals(input logic strip, input int n_bytes);
    int         sent;
    int         fault;
    int         k;
    logic [7:0] b;
    logic [8:0] em;
    logic [4:0] hv;
    write_strip(strip);
    sent = 0;
    while (sent < n_bytes) begin
      lit_q.delete();
      fault = $urandom_range(0, 9);
      if (strip) lit_q.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 8)) push_token();
      case (fault)
        7: begin
          lit_q.push_back(CH_BACKSLASH);
          do begin
            b  = 8'($urandom_range(0, 255));
            em = escape_map(b);
          end while (em[8] || b == CH_LOW_X);
          lit_q.push_back(b);
        end
        8: begin
          lit_q.push_back(CH_BACKSLASH);
          lit_q.push_back(CH_LOW_X);
          if ($urandom_range(0, 1)) push_hex_char();
          do begin
            b  = 8'($urandom_range(0, 255));
            hv = hex_digit(b);
          end while (!hv[4]);
          lit_q.push_back(b);
        end
        9: begin
          // cut off inside an escape
          lit_q.push_back(CH_BACKSLASH);
          if ($urandom_range(0, 1)) begin
            lit_q.push_back(CH_LOW_X);
            if ($urandom_range(0, 1)) push_hex_char();
          end
        end
        default: ;
      endcase
      if (fault == 7 || fault == 8) repeat ($urandom_range(0, 3)) push_token();
      if (strip) lit_q.push_back(8'($urandom_range(0, 255)));
      if (lit_q.size() == 0) lit_q.push_back(8'($urandom_range(0, 255)));
      for (k = 0; k < lit_q.size(); k++)
        send_byte(lit_q[k], k == lit_q.size() - 1, 1'b0, '0);
      sent += lit_q.size();
    end
  endtask

  // result side: random stall ahead of each transaction unless calm is set
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    dec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $error("result transaction with nothing pending: tdata %0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tuser[0] !== want.has_byte) begin
          $error("has_byte: expected %0d, got %0d", want.has_byte, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.end_of_string) begin
          $error("end_of_string: expected %0d, got %0d", want.end_of_string,
                 m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.bad_escape) begin
          $error("bad_escape: expected %0d, got %0d", want.bad_escape, m_axis_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int r;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    mismatches    = 0;
    calm          = 1'b0;
    strip_en      = 1'b1;
    esc_phase     = PH_TEXT;
    hi_nib        = 4'd0;
    at_start      = 1'b1;
    err_flag      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < N_ROWS; r++) begin
      if (PLAN[r].kind == ROW_CFG) write_strip(PLAN[r].data[0]);
      else send_byte(PLAN[r].data, PLAN[r].last, PLAN[r].typed, PLAN[r].res);
    end

    run_literals(1'b1, 150);
    run_literals(1'b0, 150);
    calm = 1'b1;
    run_literals(1'b1, 150);
    calm = 1'b0;
    run_literals(1'b0, 150);
    run_literals(1'b1, 150);
    run_literals(1'b0, 150);

    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/sed_pkg.sv
hdl/sed_decode.sv
hdl/string_escape_decoder_top.sv
hdl/sed_checker.sv
test/tb_string_escape_decoder_top.sv
